>>> rtl/core/rshr_pkg.sv
// Shared types and constants of the ray-sphere hit and bounce unit.
// No dependencies; imported by rshr_unit_vec and the top level.
package rshr_pkg;

  localparam int unsigned FracW = 16;
  localparam int unsigned UnitW = FracW + 2;
  localparam logic [UnitW-1:0] UnitOne = UnitW'(1) << FracW;

  typedef logic signed [UnitW-1:0] unit_t;

endpackage

>>> rtl/core/ray_sphere_hit_reflect_unit.sv
// Top level of the ray-sphere hit and bounce unit, Q16.16 fixed point.
// Depends on rshr_pkg and rshr_unit_vec.
//
// Takes one ray/sphere pair per cycle while the output does not stall and returns one
// result per pair, in order. It is built from bit-per-stage pipelines: a 63-stage
// square root of the discriminant, a 31-stage divide for the distance, and two
// unit-vector pipelines (31-stage root, 17-stage divide).
// A stall on the output holds the whole pipeline; nothing is lost or repeated.
// A miss returns hit low with every other field zero.
module ray_sphere_hit_reflect_unit
  import rshr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [30:0]        hit_distance_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output unit_t              normal_x_o,
  output unit_t              normal_y_o,
  output unit_t              normal_z_o,
  output unit_t              bounce_x_o,
  output unit_t              bounce_y_o,
  output unit_t              bounce_z_o
);

  localparam int unsigned SqSteps  = 63;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned FrontLen = 8 + SqSteps + 2 + DivSteps + 2;

  typedef struct packed {
    logic            miss;
    logic [63:0]     a;
    logic [66:0]     h;
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [2:0][31:0] c;
  } fr_side_t;

  typedef struct packed {
    logic             miss;
    logic [30:0]      t;
    logic [2:0][31:0] p;
    logic [2:0][31:0] d;
  } ua_side_t;

  typedef struct packed {
    logic                  miss;
    logic [30:0]           t;
    logic [2:0][31:0]      p;
    logic [2:0][UnitW-1:0] n;
  } ub_side_t;

  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic signed [31:0] o_in [3], d_in [3], c_in [3];
  assign o_in[0] = origin_x_i;
  assign o_in[1] = origin_y_i;
  assign o_in[2] = origin_z_i;
  assign d_in[0] = dir_x_i;
  assign d_in[1] = dir_y_i;
  assign d_in[2] = dir_z_i;
  assign c_in[0] = center_x_i;
  assign c_in[1] = center_y_i;
  assign c_in[2] = center_z_i;

  logic fv_q [FrontLen];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < FrontLen; s++) fv_q[s] <= 1'b0;
    end else if (adv) begin
      fv_q[0] <= in_valid_i;
      for (int s = 1; s < FrontLen; s++) fv_q[s] <= fv_q[s-1];
    end
  end

  // products, dot terms and cross terms
  logic signed [31:0] o1_q [3], d1_q [3], c1_q [3];
  logic signed [32:0] e1_q [3];
  logic [61:0]        rr1_q;
  logic signed [31:0] o2_q [3], d2_q [3], c2_q [3];
  logic [63:0]        dd2_q [3];
  logic signed [64:0] de2_q [3], pa2_q [3], pb2_q [3];
  logic [61:0]        rr2_q;
  logic signed [31:0] o3_q [3], d3_q [3], c3_q [3];
  logic [63:0]        a3_q;
  logic signed [66:0] h3_q;
  logic signed [65:0] x3_q [3];
  logic [61:0]        rr3_q;
  fr_side_t           side4_q;
  logic [62:0]        xa4_q [3];
  logic [61:0]        rr4_q;
  fr_side_t           side5_q;
  logic [61:0]        xhh5_q [3];
  logic [62:0]        xhl5_q [3];
  logic [63:0]        xll5_q [3];
  logic [61:0]        ahrh5_q, alrh5_q;
  logic [63:0]        ahrl5_q, alrl5_q;
  fr_side_t           side6_q;
  logic [125:0]       xsq6_q [3];
  logic [125:0]       ar2_6_q;
  fr_side_t           side7_q;
  logic [127:0]       cr2_7_q;
  logic [125:0]       ar2_7_q;

  logic [125:0]  sq_rem_q  [SqSteps+1];
  logic [62:0]   sq_root_q [SqSteps+1];
  fr_side_t      sq_side_q [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fr_side_t sq_in;
      for (int i = 0; i < 3; i++) begin
        logic signed [65:0] ax;
        o1_q[i] <= o_in[i];
        d1_q[i] <= d_in[i];
        c1_q[i] <= c_in[i];
        e1_q[i] <= 33'(o_in[i]) - 33'(c_in[i]);

        o2_q[i]  <= o1_q[i];
        d2_q[i]  <= d1_q[i];
        c2_q[i]  <= c1_q[i];
        dd2_q[i] <= 64'(64'(d1_q[i]) * 64'(d1_q[i]));
        de2_q[i] <= 65'(d1_q[i]) * 65'(e1_q[i]);
        pa2_q[i] <= 65'(d1_q[(i+1)%3]) * 65'(e1_q[(i+2)%3]);
        pb2_q[i] <= 65'(d1_q[(i+2)%3]) * 65'(e1_q[(i+1)%3]);

        o3_q[i] <= o2_q[i];
        d3_q[i] <= d2_q[i];
        c3_q[i] <= c2_q[i];
        x3_q[i] <= 66'(pa2_q[i]) - 66'(pb2_q[i]);

        ax = x3_q[i][65] ? -x3_q[i] : x3_q[i];
        xa4_q[i]     <= ax[62:0];
        side4_q.o[i] <= o3_q[i];
        side4_q.d[i] <= d3_q[i];
        side4_q.c[i] <= c3_q[i];

        xhh5_q[i] <= 62'(xa4_q[i][62:32]) * 62'(xa4_q[i][62:32]);
        xhl5_q[i] <= 63'(xa4_q[i][62:32]) * 63'(xa4_q[i][31:0]);
        xll5_q[i] <= 64'(xa4_q[i][31:0]) * 64'(xa4_q[i][31:0]);

        xsq6_q[i] <= (126'(xhh5_q[i]) << 64) + (126'(xhl5_q[i]) << 33) + 126'(xll5_q[i]);
      end
      rr1_q <= 62'(radius_i) * 62'(radius_i);
      rr2_q <= rr1_q;
      a3_q  <= dd2_q[0] + dd2_q[1] + dd2_q[2];
      h3_q  <= 67'(de2_q[0]) + 67'(de2_q[1]) + 67'(de2_q[2]);
      rr3_q <= rr2_q;

      side4_q.a    <= a3_q;
      side4_q.h    <= h3_q;
      side4_q.miss <= (a3_q == '0)
                   || (x3_q[0][65] ? -x3_q[0] : x3_q[0]) >= 66'sh8000000000000000
                   || (x3_q[1][65] ? -x3_q[1] : x3_q[1]) >= 66'sh8000000000000000
                   || (x3_q[2][65] ? -x3_q[2] : x3_q[2]) >= 66'sh8000000000000000;
      rr4_q <= rr3_q;

      side5_q <= side4_q;
      ahrh5_q <= 62'(side4_q.a[63:32]) * 62'(rr4_q[61:32]);
      ahrl5_q <= 64'(side4_q.a[63:32]) * 64'(rr4_q[31:0]);
      alrh5_q <= 62'(side4_q.a[31:0]) * 62'(rr4_q[61:32]);
      alrl5_q <= 64'(side4_q.a[31:0]) * 64'(rr4_q[31:0]);

      side6_q <= side5_q;
      ar2_6_q <= (126'(ahrh5_q) << 64) + (126'(ahrl5_q) << 32)
               + (126'(alrh5_q) << 32) + 126'(alrl5_q);

      side7_q <= side6_q;
      cr2_7_q <= 128'(xsq6_q[0]) + 128'(xsq6_q[1]) + 128'(xsq6_q[2]);
      ar2_7_q <= ar2_6_q;

      sq_in      = side7_q;
      sq_in.miss = side7_q.miss || (128'(ar2_7_q) < cr2_7_q);
      sq_rem_q[0]  <= 126'(128'(ar2_7_q) - cr2_7_q);
      sq_root_q[0] <= '0;
      sq_side_q[0] <= sq_in;
    end
  end

  // square root of the discriminant, one bit per stage
  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    localparam int K = SqSteps - 1 - j;
    logic [127:0] trial;
    always_comb trial = (128'(sq_root_q[j]) << (K + 1)) | (128'd1 << (2 * K));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_side_q[j+1] <= sq_side_q[j];
        if (128'(sq_rem_q[j]) >= trial) begin
          sq_rem_q[j+1]  <= 126'(128'(sq_rem_q[j]) - trial);
          sq_root_q[j+1] <= sq_root_q[j] | (63'd1 << K);
        end else begin
          sq_rem_q[j+1]  <= sq_rem_q[j];
          sq_root_q[j+1] <= sq_root_q[j];
        end
      end
    end
  end

  logic [67:0] num;
  assign num = -68'($signed(sq_side_q[SqSteps].h)) - 68'(sq_root_q[SqSteps]);

  logic [66:0] num1_q;
  fr_side_t    side_n1_q;

  logic [94:0] dv_rem_q  [DivSteps+1];
  logic [30:0] dv_quo_q  [DivSteps+1];
  logic        dv_sat_q  [DivSteps+1];
  fr_side_t    dv_side_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fr_side_t n1_in;
      n1_in      = sq_side_q[SqSteps];
      n1_in.miss = sq_side_q[SqSteps].miss || num[67];
      num1_q     <= num[66:0];
      side_n1_q  <= n1_in;

      dv_rem_q[0]  <= {12'd0, num1_q, 16'd0};
      dv_quo_q[0]  <= '0;
      dv_sat_q[0]  <= {12'd0, num1_q, 16'd0} >= (95'(side_n1_q.a) << 31);
      dv_side_q[0] <= side_n1_q;
    end
  end

  // distance divide, one quotient bit per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int K = DivSteps - 1 - j;
    logic [94:0] trial;
    always_comb trial = 95'(dv_side_q[j].a) << K;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_side_q[j+1] <= dv_side_q[j];
        dv_sat_q[j+1]  <= dv_sat_q[j];
        if (dv_rem_q[j] >= trial) begin
          dv_rem_q[j+1] <= dv_rem_q[j] - trial;
          dv_quo_q[j+1] <= dv_quo_q[j] | (31'd1 << K);
        end else begin
          dv_rem_q[j+1] <= dv_rem_q[j];
          dv_quo_q[j+1] <= dv_quo_q[j];
        end
      end
    end
  end

  logic [30:0] t_div;
  assign t_div = dv_sat_q[DivSteps] ? 31'h7FFFFFFF : dv_quo_q[DivSteps];

  logic signed [63:0] tp1_q [3];
  logic [30:0]        t1_q;
  fr_side_t           side_p1_q;
  logic signed [49:0] nv2_q [3];
  ua_side_t           ua_in_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q      <= t_div;
      side_p1_q <= dv_side_q[DivSteps];
      for (int i = 0; i < 3; i++) begin
        tp1_q[i] <= 64'($signed({1'b0, t_div})) * 64'($signed(dv_side_q[DivSteps].d[i]));
      end

      ua_in_q.miss <= side_p1_q.miss;
      ua_in_q.t    <= t1_q;
      for (int i = 0; i < 3; i++) begin
        logic signed [48:0] p;
        p = 49'($signed(side_p1_q.o[i])) + 49'(tp1_q[i] >>> 16);
        nv2_q[i] <= 50'(p) - 50'($signed(side_p1_q.c[i]));
        if (p > 49'sd2147483647) begin
          ua_in_q.p[i] <= 32'h7FFFFFFF;
        end else if (p < -49'sd2147483648) begin
          ua_in_q.p[i] <= 32'h80000000;
        end else begin
          ua_in_q.p[i] <= p[31:0];
        end
        ua_in_q.d[i] <= side_p1_q.d[i];
      end
    end
  end

  logic                 ua_valid;
  unit_t                nrm_a [3];
  logic [$bits(ua_side_t)-1:0] ua_side;

  rshr_unit_vec #(
    .W     (50),
    .SideW ($bits(ua_side_t))
  ) u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fv_q[FrontLen-1]),
    .vec_i   (nv2_q),
    .side_i  (ua_in_q),
    .valid_o (ua_valid),
    .unit_o  (nrm_a),
    .side_o  (ua_side)
  );

  ua_side_t uas;
  assign uas = ua_side;

  logic               bv_q [4];
  logic signed [49:0] dn1_q [3];
  unit_t              nrm1_q [3], nrm2_q [3], nrm3_q [3];
  ua_side_t           uas1_q, uas2_q, uas3_q;
  logic signed [35:0] dq2_q;
  logic signed [53:0] m3_q [3];
  logic signed [55:0] rv4_q [3];
  ub_side_t           ub_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 4; s++) bv_q[s] <= 1'b0;
    end else if (adv) begin
      bv_q[0] <= ua_valid;
      for (int s = 1; s < 4; s++) bv_q[s] <= bv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [51:0] dot;
      uas1_q <= uas;
      uas2_q <= uas1_q;
      uas3_q <= uas2_q;
      for (int i = 0; i < 3; i++) begin
        dn1_q[i]  <= 50'($signed(uas.d[i])) * 50'(nrm_a[i]);
        nrm1_q[i] <= nrm_a[i];
        nrm2_q[i] <= nrm1_q[i];
        nrm3_q[i] <= nrm2_q[i];
        m3_q[i]   <= 54'(dq2_q) * 54'(nrm2_q[i]);
      end
      dot   = 52'(dn1_q[0]) + 52'(dn1_q[1]) + 52'(dn1_q[2]);
      dq2_q <= 36'(dot >>> 16);

      ub_in_q.miss <= uas3_q.miss;
      ub_in_q.t    <= uas3_q.t;
      for (int i = 0; i < 3; i++) begin
        rv4_q[i]     <= (56'($signed(uas3_q.d[i])) <<< 16) - (56'(m3_q[i]) <<< 1);
        ub_in_q.p[i] <= uas3_q.p[i];
        ub_in_q.n[i] <= nrm3_q[i];
      end
    end
  end

  logic                 ub_valid;
  unit_t                bnc_b [3];
  logic [$bits(ub_side_t)-1:0] ub_side;

  rshr_unit_vec #(
    .W     (56),
    .SideW ($bits(ub_side_t))
  ) u_bounce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (bv_q[3]),
    .vec_i   (rv4_q),
    .side_i  (ub_in_q),
    .valid_o (ub_valid),
    .unit_o  (bnc_b),
    .side_o  (ub_side)
  );

  ub_side_t ubs;
  assign ubs = ub_side;

  logic               hit_q;
  logic [30:0]        dist_q;
  logic signed [31:0] pt_q [3];
  unit_t              nrm_q [3], bnc_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ub_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= !ubs.miss;
      dist_q <= ubs.miss ? '0 : ubs.t;
      for (int i = 0; i < 3; i++) begin
        pt_q[i]  <= ubs.miss ? '0 : $signed(ubs.p[i]);
        nrm_q[i] <= ubs.miss ? '0 : $signed(ubs.n[i]);
        bnc_q[i] <= ubs.miss ? '0 : bnc_b[i];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];
  assign normal_x_o     = nrm_q[0];
  assign normal_y_o     = nrm_q[1];
  assign normal_z_o     = nrm_q[2];
  assign bounce_x_o     = bnc_q[0];
  assign bounce_y_o     = bnc_q[1];
  assign bounce_z_o     = bnc_q[2];

endmodule

>>> rtl/core/rshr_unit_vec.sv
// Pipelined unit-vector stage, Q2.16 output: normalize, sum of squares, root, divide.
// Depends on rshr_pkg; carries a sideband word in step with the data.
module rshr_unit_vec
  import rshr_pkg::*;
#(
  parameter int unsigned W     = 50,
  parameter int unsigned SideW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic signed [W-1:0]     vec_i [3],
  input  logic [SideW-1:0]        side_i,
  output logic                    valid_o,
  output unit_t                   unit_o [3],
  output logic [SideW-1:0]        side_o
);

  localparam int unsigned PosW  = $clog2(W);
  localparam int unsigned NormW = 30;
  localparam int unsigned SqW   = 2 * NormW + 2;
  localparam int unsigned RootW = NormW + 1;
  localparam int unsigned QW    = FracW + 1;
  localparam int unsigned RemW  = RootW + QW;
  localparam int unsigned Lat   = 6 + RootW + 1 + QW + 1;

  logic             vld_q  [Lat];
  logic [SideW-1:0] side_q [Lat];

  logic [W-1:0]        mag1_q [3];
  logic [2:0]          sgn1_q;
  logic [W-1:0]        mag2_q [3];
  logic [W-1:0]        max2_q;
  logic [2:0]          sgn2_q;
  logic [W-1:0]        mag3_q [3];
  logic [PosW-1:0]     pos3_q;
  logic [3:0]          fl3_q;
  logic [NormW-1:0]    n4_q [3];
  logic [3:0]          fl4_q;
  logic [2*NormW-1:0]  sq5_q [3];
  logic [NormW-1:0]    n5_q [3];
  logic [3:0]          fl5_q;

  logic [SqW-1:0]   sr_rem_q  [RootW+1];
  logic [RootW-1:0] sr_root_q [RootW+1];
  logic [NormW-1:0] sr_n_q    [RootW+1][3];
  logic [3:0]       sr_fl_q   [RootW+1];

  logic [RootW-1:0] dv_len_q [QW+1];
  logic [RemW-1:0]  dv_rem_q [QW+1][3];
  logic [QW-1:0]    dv_quo_q [QW+1][3];
  logic [3:0]       dv_fl_q  [QW+1];

  unit_t unit_q [3];

  logic [W-1:0]    mx;
  logic [PosW-1:0] pos;

  always_comb begin
    mx = mag1_q[0];
    if (mag1_q[1] > mx) mx = mag1_q[1];
    if (mag1_q[2] > mx) mx = mag1_q[2];
  end

  always_comb begin
    pos = '0;
    for (int b = 0; b < W; b++) begin
      if (max2_q[b]) pos = PosW'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Lat; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < Lat; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < Lat; s++) side_q[s] <= side_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= vec_i[i][W-1] ? W'(-vec_i[i]) : W'(vec_i[i]);
        sgn1_q[i] <= vec_i[i][W-1];
        mag2_q[i] <= mag1_q[i];
        mag3_q[i] <= mag2_q[i];
        if (pos3_q >= PosW'(NormW - 1)) begin
          n4_q[i] <= NormW'(mag3_q[i] >> (pos3_q - PosW'(NormW - 1)));
        end else begin
          n4_q[i] <= mag3_q[i][NormW-1:0] << (PosW'(NormW - 1) - pos3_q);
        end
        sq5_q[i] <= (2*NormW)'(n4_q[i]) * (2*NormW)'(n4_q[i]);
        n5_q[i]  <= n4_q[i];
      end
      max2_q <= mx;
      sgn2_q <= sgn1_q;
      pos3_q <= pos;
      fl3_q  <= {max2_q == '0, sgn2_q};
      fl4_q  <= fl3_q;
      fl5_q  <= fl4_q;
      sr_rem_q[0]  <= SqW'(sq5_q[0]) + SqW'(sq5_q[1]) + SqW'(sq5_q[2]);
      sr_root_q[0] <= '0;
      sr_fl_q[0]   <= fl5_q;
      for (int i = 0; i < 3; i++) sr_n_q[0][i] <= n5_q[i];
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    localparam int K = RootW - 1 - j;
    logic [SqW+1:0] trial;
    always_comb begin
      trial = ((SqW+2)'(sr_root_q[j]) << (K + 1)) | ((SqW+2)'(1) << (2 * K));
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if ((SqW+2)'(sr_rem_q[j]) >= trial) begin
          sr_rem_q[j+1]  <= SqW'((SqW+2)'(sr_rem_q[j]) - trial);
          sr_root_q[j+1] <= sr_root_q[j] | (RootW'(1) << K);
        end else begin
          sr_rem_q[j+1]  <= sr_rem_q[j];
          sr_root_q[j+1] <= sr_root_q[j];
        end
        sr_fl_q[j+1] <= sr_fl_q[j];
        for (int i = 0; i < 3; i++) sr_n_q[j+1][i] <= sr_n_q[j][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_len_q[0] <= sr_root_q[RootW];
      dv_fl_q[0]  <= sr_fl_q[RootW];
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= RemW'({sr_n_q[RootW][i], {FracW{1'b0}}});
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [RemW-1:0] trial;
    always_comb trial = RemW'(dv_len_q[j]) << K;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_len_q[j+1] <= dv_len_q[j];
        dv_fl_q[j+1]  <= dv_fl_q[j];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_q[j][i] >= trial) begin
            dv_rem_q[j+1][i] <= dv_rem_q[j][i] - trial;
            dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (QW'(1) << K);
          end else begin
            dv_rem_q[j+1][i] <= dv_rem_q[j][i];
            dv_quo_q[j+1][i] <= dv_quo_q[j][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        logic [UnitW-1:0] cu;
        cu = UnitW'(dv_quo_q[QW][i]);
        if (cu > UnitOne) cu = UnitOne;
        if (dv_fl_q[QW][3]) begin
          unit_q[i] <= '0;
        end else if (dv_fl_q[QW][i]) begin
          unit_q[i] <= -$signed(cu);
        end else begin
          unit_q[i] <= $signed(cu);
        end
      end
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign side_o  = side_q[Lat-1];
  assign unit_o  = unit_q;

endmodule
